[src/tasre_pkg.sv]
// tasre_pkg: shared types and constants for the three-axis speed ramp block.
// No dependencies; imported by every module under src.
package tasre_pkg;

    // Field widths
    localparam int VEL_W   = 21;   // target velocity, um/s, signed
    localparam int SPD_W   = 21;   // speed, 1/256 steps/s, signed
    localparam int MAXS_W  = 20;   // speed limit / stop threshold
    localparam int INC_W   = 16;   // ramp increment
    localparam int DECAY_W = 16;   // brake multiplier, /65536
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 20;
    localparam int NUM_SW  = 3;    // axes that have end switches and limits

    // um/s to 1/256 steps/s, scaled by 2^16
    localparam logic signed [22:0] CONV_MUL = 23'sd2586610;
    localparam int CONV_SHIFT = 16;

    // Operation codes (tuser)
    localparam logic OP_CMD  = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_Z   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RAMP    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY   = 3'd5;

    // Reset values
    localparam logic [MAXS_W-1:0]  RST_MAX_X = 20'd844800;
    localparam logic [MAXS_W-1:0]  RST_MAX_Y = 20'd1024000;
    localparam logic [MAXS_W-1:0]  RST_MAX_Z = 20'd1024000;
    localparam logic [INC_W-1:0]   RST_RAMP  = 16'd1280;
    localparam logic [MAXS_W-1:0]  RST_STOP  = 20'd256000;
    localparam logic [DECAY_W-1:0] RST_DECAY = 16'd64881;

    // Full register set
    typedef struct packed {
        logic [NUM_SW-1:0][MAXS_W-1:0] max_speed;
        logic [INC_W-1:0]              ramp_inc;
        logic [MAXS_W-1:0]             stop_thr;
        logic [DECAY_W-1:0]            decay;
    } t_cfg;

    // Settings seen by one axis
    typedef struct packed {
        logic [MAXS_W-1:0]  max_speed;
        logic [INC_W-1:0]   ramp_inc;
        logic [MAXS_W-1:0]  stop_thr;
        logic [DECAY_W-1:0] decay;
    } t_axis_cfg;

endpackage

[src/three_axis_speed_ramp_endstop_top.sv]
// Channel   Dir  Handshake                  Payload
// s_axis    in   i_s_axis_tvalid/o_tready   tdata: vel_x,vel_y,vel_z,gripper_request,
//                                           upper_switches,lower_switches; tuser: operation
// m_axis    out  o_m_axis_tvalid/i_tready   tdata: speed_x,speed_y,speed_z,gripper_on
// cfg       in   i_cfg_we                   i_cfg_index, i_cfg_data
//
// The input word is held in the input register, then its result in the result register;
// a stalled result side holds the word in the input register. One word per cycle is
// sustained while the result side takes every word, set by the combinational state
// update in tasre_axis (multiply, shift, compare per axis).
// Reset (i_rst_n low, synchronous) clears speeds, targets, gripper and both stages.
// Output stalls back up through the input register to o_s_axis_tready.
// Depends on tasre_pkg, tasre_cfg, tasre_axis.
module three_axis_speed_ramp_endstop_top
    import tasre_pkg::*;
#(
    parameter int AXIS_COUNT = 3
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input words
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    // [20:0] vel_x, [41:21] vel_y, [62:42] vel_z, [63] gripper_request,
    // [66:64] upper_switches, [69:67] lower_switches, [71:70] zero
    input  logic [71:0]          i_s_axis_tdata,
    input  logic [0:0]           i_s_axis_tuser,   // [0] operation
    // result words
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    // [20:0] speed_x, [41:21] speed_y, [62:42] speed_z, [63] gripper_on
    output logic [63:0]          o_m_axis_tdata,
    // configuration writes
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data
);

    t_cfg w_cfg;

    // input register
    logic                                r_in_valid;
    logic                                r_in_op;
    logic [NUM_SW-1:0][VEL_W-1:0]        r_in_vel;
    logic                                r_in_grip;
    logic [NUM_SW-1:0]                   r_in_upper, r_in_lower;

    // result register
    logic                                r_out_valid;
    logic [NUM_SW-1:0][SPD_W-1:0]        r_out_speed;
    logic                                r_out_grip;

    logic                                r_gripper, n_gripper;
    logic signed [SPD_W-1:0]             w_next_speed [AXIS_COUNT];
    logic [NUM_SW-1:0][SPD_W-1:0]        w_report;
    logic                                w_out_free, w_adv, w_in_acc;

    tasre_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    // handshake
    assign w_out_free      = !r_out_valid || i_m_axis_tready;
    assign w_adv           = r_in_valid && w_out_free;
    assign o_s_axis_tready = !r_in_valid || w_out_free;
    assign w_in_acc        = i_s_axis_tvalid && o_s_axis_tready;

    // input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_acc) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_in_op     <= i_s_axis_tuser[0];
            r_in_vel[0] <= i_s_axis_tdata[20:0];
            r_in_vel[1] <= i_s_axis_tdata[41:21];
            r_in_vel[2] <= i_s_axis_tdata[62:42];
            r_in_grip   <= i_s_axis_tdata[63];
            r_in_upper  <= i_s_axis_tdata[66:64];
            r_in_lower  <= i_s_axis_tdata[69:67];
        end
    end

    // per-axis datapath; axes past the third get zero velocity, a zero limit and no switches
    for (genvar g = 0; g < AXIS_COUNT; g++) begin : g_axis
        t_axis_cfg               w_acfg;
        logic signed [VEL_W-1:0] w_vel;
        logic                    w_up, w_lo;
        if (g < NUM_SW) begin : g_sw
            assign w_vel = r_in_vel[g];
            assign w_up  = r_in_upper[g];
            assign w_lo  = r_in_lower[g];
            assign w_acfg.max_speed = w_cfg.max_speed[g];
        end else begin : g_nosw
            assign w_vel = '0;
            assign w_up  = 1'b0;
            assign w_lo  = 1'b0;
            assign w_acfg.max_speed = '0;
        end
        assign w_acfg.ramp_inc = w_cfg.ramp_inc;
        assign w_acfg.stop_thr = w_cfg.stop_thr;
        assign w_acfg.decay    = w_cfg.decay;

        tasre_axis u_axis (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_en         (w_adv),
            .i_op         (r_in_op),
            .i_vel        (w_vel),
            .i_upper      (w_up),
            .i_lower      (w_lo),
            .i_cfg        (w_acfg),
            .o_next_speed (w_next_speed[g])
        );
    end

    // reported speeds; missing axes read as zero
    for (genvar k = 0; k < NUM_SW; k++) begin : g_report
        if (k < AXIS_COUNT) begin : g_live
            assign w_report[k] = w_next_speed[k];
        end else begin : g_zero
            assign w_report[k] = '0;
        end
    end

    // gripper latch
    assign n_gripper = (w_adv && r_in_op == OP_CMD) ? r_in_grip : r_gripper;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gripper <= 1'b0;
        end else begin
            r_gripper <= n_gripper;
        end
    end

    // result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_speed <= w_report;
            r_out_grip  <= n_gripper;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out_grip, r_out_speed[2], r_out_speed[1], r_out_speed[0]};

    // a result only appears after a word sat in the input register
    a_out_from_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_in_valid))
        else $error("result word without a source word");
    // a tick leaves the gripper latch alone
    a_tick_gripper: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_in_op == OP_TICK) |=> (r_gripper == $past(r_gripper)))
        else $error("gripper changed on a tick");
    // a held input word is not lost while the result side is stalled
    a_in_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_out_free) |=> r_in_valid)
        else $error("input word dropped during stall");

endmodule

[src/tasre_cfg.sv]
// tasre_cfg: configuration register file, write-only, indexed writes.
// Depends on tasre_pkg.
module tasre_cfg
    import tasre_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;

    // Register writes; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_speed[0] <= RST_MAX_X;
            r_cfg.max_speed[1] <= RST_MAX_Y;
            r_cfg.max_speed[2] <= RST_MAX_Z;
            r_cfg.ramp_inc     <= RST_RAMP;
            r_cfg.stop_thr     <= RST_STOP;
            r_cfg.decay        <= RST_DECAY;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MAX_X: r_cfg.max_speed[0] <= i_cfg_data;
                CFG_MAX_Y: r_cfg.max_speed[1] <= i_cfg_data;
                CFG_MAX_Z: r_cfg.max_speed[2] <= i_cfg_data;
                CFG_RAMP:  r_cfg.ramp_inc     <= i_cfg_data[INC_W-1:0];
                CFG_STOP:  r_cfg.stop_thr     <= i_cfg_data;
                CFG_DECAY: r_cfg.decay        <= i_cfg_data[DECAY_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

[src/tasre_axis.sv]
// tasre_axis: one axis - target conversion/clamp, slew ramp and end-switch brake.
// Holds the axis target and current speed. Depends on tasre_pkg.
module tasre_axis
    import tasre_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,        // item advances this cycle
    input  logic                    i_op,
    input  logic signed [VEL_W-1:0] i_vel,
    input  logic                    i_upper,
    input  logic                    i_lower,
    input  t_axis_cfg               i_cfg,
    output logic signed [SPD_W-1:0] o_next_speed
);

    logic signed [SPD_W-1:0] r_target, n_target;
    logic signed [SPD_W-1:0] r_current, n_current;

    logic signed [43:0]       w_prod;
    logic signed [27:0]       w_conv, w_lim, w_clamp;
    logic signed [SPD_W:0]    w_diff, w_inc, w_up, w_dn;
    logic signed [SPD_W-1:0]  w_ramp, w_braked;
    logic                     w_neg, w_pos, w_brake;
    logic [SPD_W-1:0]         w_mag, w_bmag;
    logic [SPD_W+DECAY_W-1:0] w_bprod;

    // Command: convert um/s to speed units (floor of product / 2^16), clamp
    always_comb begin
        w_prod = i_vel * CONV_MUL;
        w_conv = w_prod[43:CONV_SHIFT];
        w_lim  = $signed({8'd0, i_cfg.max_speed});
        if (w_conv > w_lim)       w_clamp = w_lim;
        else if (w_conv < -w_lim) w_clamp = -w_lim;
        else                      w_clamp = w_conv;
    end

    // Tick: slew toward target by at most the ramp increment
    always_comb begin
        w_diff = {r_target[SPD_W-1], r_target} - {r_current[SPD_W-1], r_current};
        w_inc  = $signed({{(SPD_W+1-INC_W){1'b0}}, i_cfg.ramp_inc});
        w_up   = {r_current[SPD_W-1], r_current} + w_inc;
        w_dn   = {r_current[SPD_W-1], r_current} - w_inc;
        if (w_diff > w_inc)       w_ramp = w_up[SPD_W-1:0];
        else if (w_diff < -w_inc) w_ramp = w_dn[SPD_W-1:0];
        else                      w_ramp = r_target;
    end

    // Tick: brake when the switch in the direction of motion is pressed
    always_comb begin
        w_neg   = w_ramp[SPD_W-1];
        w_pos   = !w_neg && (w_ramp != '0);
        w_brake = (i_upper && w_pos) || (i_lower && !w_pos);
        w_mag   = w_neg ? 21'(-w_ramp) : w_ramp;
        w_bprod = w_mag * i_cfg.decay;
        w_bmag  = w_bprod[SPD_W+DECAY_W-1:DECAY_W];
        if (w_bmag < {1'b0, i_cfg.stop_thr}) w_braked = '0;
        else if (w_neg)                      w_braked = -$signed(w_bmag);
        else                                 w_braked = $signed(w_bmag);
    end

    // Next state
    always_comb begin
        n_target  = r_target;
        n_current = r_current;
        if (i_en) begin
            if (i_op == OP_CMD) n_target  = w_clamp[SPD_W-1:0];
            else                n_current = w_brake ? w_braked : w_ramp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target  <= '0;
            r_current <= '0;
        end else begin
            r_target  <= n_target;
            r_current <= n_current;
        end
    end

    assign o_next_speed = n_current;

    // A command never moves the speed, a tick never moves the target
    a_cmd_holds_speed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && i_op == OP_CMD) |=> $stable(r_current))
        else $error("axis speed changed on a command");
    a_tick_holds_target: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && i_op == OP_TICK) |=> $stable(r_target))
        else $error("axis target changed on a tick");
    a_idle_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_en |=> ($stable(r_current) && $stable(r_target)))
        else $error("axis state changed without an item");

endmodule

[bench/speed_ramp_monitor.sv]
`timescale 1ns / 100ps
// speed_ramp_monitor: watches the input, result and register-write channels of the
// speed ramp block, predicts every result word and compares it field by field.
// Depends on tasre_pkg for widths and codes.
module speed_ramp_monitor
    import tasre_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  logic [71:0]          i_in_data,
    input  logic [0:0]           i_in_user,
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  logic [63:0]          i_out_data,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    output int                   o_mismatches,
    output int                   o_pending
);

    // um/s to speed units, scaled by 2^16
    localparam longint UM_TO_SPEED = 2586610;

    // result word layout, highest bits first
    typedef struct packed {
        logic             grip;
        logic [SPD_W-1:0] sz;
        logic [SPD_W-1:0] sy;
        logic [SPD_W-1:0] sx;
    } t_speed_report;

    // Predicted block state
    logic signed [SPD_W-1:0] target_spd [NUM_SW];
    logic signed [SPD_W-1:0] cur_spd [NUM_SW];
    logic                    grip_latch;
    logic [MAXS_W-1:0]       max_spd [NUM_SW];
    logic [INC_W-1:0]        ramp_inc;
    logic [MAXS_W-1:0]       stop_thr;
    logic [DECAY_W-1:0]      decay_f;

    t_speed_report pending_reports [$];
    int            errors = 0;

    initial begin
        o_mismatches = 0;
        o_pending    = 0;
    end

    // Velocity command to clamped target speed; >>> on a signed value floors
    function automatic logic signed [SPD_W-1:0] vel_to_target(
        logic signed [VEL_W-1:0] vel, logic [MAXS_W-1:0] lim);
        longint t;
        t = (longint'(vel) * UM_TO_SPEED) >>> 16;
        if (t > longint'(lim))
            t = longint'(lim);
        if (t < -longint'(lim))
            t = -longint'(lim);
        return t[SPD_W-1:0];
    endfunction

    // End-switch braking: scale magnitude, keep sign, zero below the threshold
    function automatic logic signed [SPD_W-1:0] brake_speed(logic signed [SPD_W-1:0] s);
        longint mag;
        longint res;
        mag = (s < 0) ? -longint'(s) : longint'(s);
        mag = (mag * longint'(decay_f)) >>> 16;
        if (mag < longint'(stop_thr))
            return '0;
        res = (s < 0) ? -mag : mag;
        return res[SPD_W-1:0];
    endfunction

    task automatic check_field(string name, longint want, longint got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin : track
        t_speed_report           got;
        t_speed_report           want;
        logic signed [VEL_W-1:0] vel [NUM_SW];
        logic [NUM_SW-1:0]       up_sw;
        logic [NUM_SW-1:0]       lo_sw;
        longint                  cur;
        longint                  diff;
        longint                  step;
        logic signed [SPD_W-1:0] spd;
        if (!i_rst_n) begin
            for (int a = 0; a < NUM_SW; a++) begin
                target_spd[a] = '0;
                cur_spd[a]    = '0;
            end
            grip_latch = 1'b0;
            max_spd[0] = RST_MAX_X;
            max_spd[1] = RST_MAX_Y;
            max_spd[2] = RST_MAX_Z;
            ramp_inc   = RST_RAMP;
            stop_thr   = RST_STOP;
            decay_f    = RST_DECAY;
            pending_reports.delete();
        end else begin
            // Result word: compare against the oldest prediction
            if (i_out_valid && i_out_ready) begin
                got = i_out_data;
                if (pending_reports.size() == 0) begin
                    $error("result word with no prediction waiting: %h", i_out_data);
                    errors++;
                end else begin
                    want = pending_reports.pop_front();
                    check_field("speed_x", $signed(want.sx), $signed(got.sx));
                    check_field("speed_y", $signed(want.sy), $signed(got.sy));
                    check_field("speed_z", $signed(want.sz), $signed(got.sz));
                    check_field("gripper_on", want.grip, got.grip);
                end
            end

            // Input word: advance the predicted state
            if (i_in_valid && i_in_ready) begin
                vel[0] = i_in_data[20:0];
                vel[1] = i_in_data[41:21];
                vel[2] = i_in_data[62:42];
                up_sw  = i_in_data[66:64];
                lo_sw  = i_in_data[69:67];
                if (i_in_user[0] == OP_CMD) begin
                    for (int a = 0; a < NUM_SW; a++)
                        target_spd[a] = vel_to_target(vel[a], max_spd[a]);
                    grip_latch = i_in_data[63];
                end else begin
                    for (int a = 0; a < NUM_SW; a++) begin
                        cur  = longint'(cur_spd[a]);
                        diff = longint'(target_spd[a]) - cur;
                        step = longint'(ramp_inc);
                        if (diff > step)
                            cur = cur + step;
                        else if (diff < -step)
                            cur = cur - step;
                        else
                            cur = longint'(target_spd[a]);
                        spd = cur[SPD_W-1:0];
                        if ((up_sw[a] && spd > 0) || (lo_sw[a] && spd <= 0))
                            spd = brake_speed(spd);
                        cur_spd[a] = spd;
                    end
                end
                want.sx   = cur_spd[0];
                want.sy   = cur_spd[1];
                want.sz   = cur_spd[2];
                want.grip = grip_latch;
                pending_reports.push_back(want);
            end

            // Register writes; unknown indexes are dropped
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_MAX_X: max_spd[0] = i_cfg_data;
                    CFG_MAX_Y: max_spd[1] = i_cfg_data;
                    CFG_MAX_Z: max_spd[2] = i_cfg_data;
                    CFG_RAMP:  ramp_inc   = i_cfg_data[INC_W-1:0];
                    CFG_STOP:  stop_thr   = i_cfg_data;
                    CFG_DECAY: decay_f    = i_cfg_data[DECAY_W-1:0];
                    default: ;
                endcase
            end
        end
        o_mismatches <= errors;
        o_pending    <= pending_reports.size();
    end

endmodule

[bench/three_axis_speed_ramp_endstop_top_test.sv]
`timescale 1ns / 100ps
// three_axis_speed_ramp_endstop_top_test: drives commands, ticks and register
// writes into the speed ramp block and reports the verdict of speed_ramp_monitor.
// Depends on tasre_pkg, three_axis_speed_ramp_endstop_top and speed_ramp_monitor.
module three_axis_speed_ramp_endstop_top_test;
    import tasre_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_7 = 3'd7;
    localparam logic signed [VEL_W-1:0] VEL_MAX = 21'sh0FFFFF;
    localparam logic signed [VEL_W-1:0] VEL_MIN = 21'sh100000;
    localparam logic [MAXS_W-1:0] FULL20 = 20'hFFFFF;
    localparam logic [INC_W-1:0]  FULL16 = 16'hFFFF;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 s_valid;
    logic                 s_ready;
    logic [71:0]          s_data;
    logic [0:0]           s_user;
    logic                 m_valid;
    logic                 m_ready;
    logic [63:0]          m_data;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DAT_W-1:0] cfg_data;

    int mismatches;
    int pending;
    int quiet_cycles;
    bit calm;

    three_axis_speed_ramp_endstop_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    speed_ramp_monitor monitor (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_valid),
        .i_in_ready   (s_ready),
        .i_in_data    (s_data),
        .i_in_user    (s_user),
        .i_out_valid  (m_valid),
        .i_out_ready  (m_ready),
        .i_out_data   (m_data),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    // 10 ns clock
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Result side backpressure
    always @(posedge i_clk)
        m_ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 15);

    // Watchdog on cycles without any word moving
    always @(posedge i_clk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // One input word; optional idle cycles first, returns at the accepting edge
    task automatic push_word(logic op, logic signed [VEL_W-1:0] vx, vy, vz, logic grip,
                             logic [NUM_SW-1:0] up_sw, lo_sw);
        if (!calm) begin
            while ($urandom_range(0, 99) < 15) begin
                s_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        s_valid <= 1'b1;
        s_user  <= op;
        s_data  <= {2'b00, lo_sw, up_sw, grip, vz, vy, vx};
        do @(posedge i_clk); while (!s_ready);
    endtask

    // Switch fields carry noise on a command
    task automatic send_command(logic signed [VEL_W-1:0] vx, vy, vz, logic grip);
        push_word(OP_CMD, vx, vy, vz, grip, 3'($urandom), 3'($urandom));
    endtask

    // Velocity and gripper fields carry noise on a tick
    task automatic send_tick(logic [NUM_SW-1:0] up_sw, lo_sw);
        push_word(OP_TICK, 21'($urandom), 21'($urandom), 21'($urandom), 1'($urandom),
                  up_sw, lo_sw);
    endtask

    // Stop sending and wait until every result word is back
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic program_regs(logic [MAXS_W-1:0] mx, my, mz, logic [INC_W-1:0] ramp,
                                logic [MAXS_W-1:0] stop, logic [DECAY_W-1:0] decay);
        write_reg(CFG_MAX_X, mx);
        write_reg(CFG_MAX_Y, my);
        write_reg(CFG_MAX_Z, mz);
        write_reg(CFG_RAMP, 20'(ramp));
        write_reg(CFG_STOP, stop);
        write_reg(CFG_DECAY, 20'(decay));
        // index outside the register map must change nothing
        write_reg($urandom_range(0, 1) ? CFG_SPARE_6 : CFG_SPARE_7, 20'($urandom));
    endtask

    function automatic logic signed [VEL_W-1:0] rand_vel();
        case ($urandom_range(0, 3))
            0: return 21'($urandom);
            1: return 21'(int'($urandom_range(0, 60000)) - 30000);
            2: return $urandom_range(0, 1) ? VEL_MAX : VEL_MIN;
            default: return 21'(int'($urandom_range(0, 600)) - 300);
        endcase
    endfunction

    function automatic logic [NUM_SW-1:0] rand_switches();
        return ($urandom_range(0, 99) < 65) ? 3'b000 : 3'($urandom);
    endfunction

    function automatic logic [MAXS_W-1:0] rand_limit();
        case ($urandom_range(0, 3))
            0: return FULL20;
            1: return 20'($urandom_range(0, 4000));
            default: return 20'($urandom);
        endcase
    endfunction

    // Mostly ticks with commands mixed in, with switches pressed now and then
    task automatic run_random(int count);
        repeat (count) begin
            if ($urandom_range(0, 99) < 25)
                send_command(rand_vel(), rand_vel(), rand_vel(), 1'($urandom));
            else
                send_tick(rand_switches(), rand_switches());
        end
    endtask

    initial begin
        logic [INC_W-1:0] ramp;
        i_rst_n      = 1'b0;
        s_valid      = 1'b0;
        s_data       = '0;
        s_user       = OP_CMD;
        m_ready      = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = CFG_MAX_X;
        cfg_data     = '0;
        calm         = 1'b0;
        quiet_cycles = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: clamping, ramp steps, both brake directions
        send_command(VEL_MAX, VEL_MIN, 21'sd0, 1'b1);
        repeat (3) send_tick(3'b000, 3'b000);
        send_tick(3'b111, 3'b000);
        send_tick(3'b000, 3'b111);
        send_tick(3'b111, 3'b111);
        // small velocities round toward minus infinity
        send_command(-21'sd1, 21'sd1, 21'sd26000, 1'b0);
        send_tick(3'b000, 3'b000);
        send_command(21'sd0, 21'sd0, 21'sd0, 1'b0);
        repeat (2) send_tick(3'b000, 3'b000);
        drain();

        // Widest limits, largest step, no stop threshold, weakest braking
        program_regs(FULL20, FULL20, FULL20, FULL16, 20'd0, FULL16);
        send_command(VEL_MAX, VEL_MIN, VEL_MAX, 1'b1);
        repeat (4) send_tick(3'b000, 3'b000);
        send_tick(3'b101, 3'b010);
        send_tick(3'b111, 3'b111);
        run_random(150);
        drain();

        // Smallest limits and step, largest threshold, full braking; limits drop
        // while the axes are still moving
        program_regs(20'd0, 20'd0, 20'd0, 16'd0, FULL20, 16'd0);
        run_random(100);
        drain();

        // No idling on either side
        calm <= 1'b1;
        program_regs(rand_limit(), rand_limit(), rand_limit(),
                     16'($urandom_range(1000, 20000)), 20'($urandom_range(1000, 100000)),
                     16'($urandom_range(50000, 65535)));
        run_random(150);
        drain();
        calm <= 1'b0;

        repeat (5) begin
            case ($urandom_range(0, 2))
                0: ramp = 16'($urandom_range(1, 16));
                1: ramp = 16'($urandom_range(1000, 70000));
                default: ramp = 16'($urandom);
            endcase
            program_regs(rand_limit(), rand_limit(), rand_limit(), ramp,
                         $urandom_range(0, 1) ? 20'($urandom_range(0, 300000)) : 20'($urandom),
                         $urandom_range(0, 1) ? 16'($urandom_range(40000, 65535))
                                              : 16'($urandom));
            run_random(130);
            drain();
        end

        repeat (10) @(posedge i_clk);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

[files.f]
src/tasre_pkg.sv
src/tasre_cfg.sv
src/tasre_axis.sv
src/three_axis_speed_ramp_endstop_top.sv
bench/speed_ramp_monitor.sv
bench/three_axis_speed_ramp_endstop_top_test.sv
